// ----- rtl/pit_pkg.sv -----
// ----------------------------------------------------------------------------
// pit_pkg: shared types and constants of the pending-interest table
// Command kinds, status codes, interface states and the transaction token
// that travels down the chain of table cells.
// ----------------------------------------------------------------------------
package pit_pkg;

  localparam int NUM_ENTRIES_DEF = 16;
  localparam int NUM_IFACES_DEF  = 8;
  localparam int NAME_BYTES_DEF  = 8;

  localparam int KEY_W   = 64;
  localparam int KIND_W  = 3;
  localparam int IFACE_W = 3;
  localparam int STATE_W = 2;
  localparam int STAT_W  = 2;

  // command kinds
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ADD    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_UPDATE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

  // interface states
  localparam logic [STATE_W-1:0] IF_CLOSED  = 2'd0;
  localparam logic [STATE_W-1:0] IF_WAITING = 2'd1;
  localparam logic [STATE_W-1:0] IF_OPEN    = 2'd2;

  // One command in flight plus what the cells it has passed have found.
  // hit marks the first match (or, for add, the slot taken).
  typedef struct packed {
    logic                 active;
    logic [KIND_W-1:0]    kind;
    logic [KEY_W-1:0]     key;
    logic [IFACE_W-1:0]   iface;
    logic [STATE_W-1:0]   new_state;
    logic                 hit;
    logic                 all_closed;
    logic [STATE_W-1:0]   iface_state;
    logic                 waiting_valid;
    logic [IFACE_W-1:0]   waiting_iface;
  } pit_tok_t;

endpackage

// ----- rtl/pit_cell.sv -----
// ----------------------------------------------------------------------------
// pit_cell: one table entry
// Holds one entry and acts on the token passing by, then hands the token on.
// ----------------------------------------------------------------------------
module pit_cell
  import pit_pkg::*;
#(
  parameter int NUM_IFACES = NUM_IFACES_DEF,
  parameter int NAME_BYTES = NAME_BYTES_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  pit_tok_t tok_in,
  output pit_tok_t tok_out
);

  localparam int NAME_W = 8 * NAME_BYTES;
  localparam int IFS_W  = STATE_W * NUM_IFACES;

  logic              valid;
  logic              valid_next;
  logic [NAME_W-1:0] name;
  logic [NAME_W-1:0] name_next;
  logic [IFS_W-1:0]  states;
  logic [IFS_W-1:0]  states_next;
  pit_tok_t          tok_next;

  logic               match;
  logic [STATE_W-1:0] sel_state;
  logic               has_wait;
  logic [IFACE_W-1:0] wait_idx;

  assign match = valid && (name == tok_in.key[NAME_W-1:0]);

  // pick the addressed interface and the lowest waiting one
  always_comb begin
    sel_state = IF_CLOSED;
    has_wait  = 1'b0;
    wait_idx  = '0;
    for (int j = 0; j < NUM_IFACES; j++) begin
      if (int'(tok_in.iface) == j) begin
        sel_state = states[STATE_W*j +: STATE_W];
      end
    end
    for (int j = NUM_IFACES - 1; j >= 0; j--) begin
      if (states[STATE_W*j +: STATE_W] == IF_WAITING) begin
        has_wait = 1'b1;
        wait_idx = IFACE_W'(j);
      end
    end
  end

  always_comb begin
    valid_next  = valid;
    name_next   = name;
    states_next = states;
    tok_next    = tok_in;
    if (tok_in.active) begin
      unique case (tok_in.kind)
        KIND_LOOKUP: begin
          if (match && !tok_in.hit) begin
            tok_next.hit         = 1'b1;
            tok_next.all_closed  = (states == '0);
            tok_next.iface_state = sel_state;
          end
          if (match && !tok_in.waiting_valid && has_wait) begin
            tok_next.waiting_valid = 1'b1;
            tok_next.waiting_iface = wait_idx;
          end
        end
        KIND_ADD: begin
          if (!valid && !tok_in.hit) begin
            valid_next   = 1'b1;
            name_next    = tok_in.key[NAME_W-1:0];
            states_next  = {NUM_IFACES{tok_in.new_state}};
            tok_next.hit = 1'b1;
          end
        end
        KIND_REMOVE: begin
          if (match && !tok_in.hit) begin
            valid_next   = 1'b0;
            tok_next.hit = 1'b1;
          end
        end
        KIND_UPDATE: begin
          if (match && !tok_in.hit) begin
            tok_next.hit = 1'b1;
            for (int j = 0; j < NUM_IFACES; j++) begin
              if (int'(tok_in.iface) == j) begin
                states_next[STATE_W*j +: STATE_W] = tok_in.new_state;
              end
            end
          end
        end
        KIND_CLEAR: begin
          valid_next = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      tok_out <= '0;
    end else begin
      valid   <= valid_next;
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    name   <= name_next;
    states <= states_next;
  end

endmodule

// ----- rtl/pending_interest_table.sv -----
// ----------------------------------------------------------------------------
// pending_interest_table: pending-interest table as a chain of entry cells
// Lookup, add, remove, update and clear commands on a table of named entries.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a transaction is taken at a rising edge with start high
//   and busy low; kind, name_key, iface and new_state are sampled there.
//   The key is masked to NAME_BYTES bytes on entry.
//   Result channel: done is high for exactly one cycle and status, found,
//   all_closed, waiting_valid, waiting_iface and iface_state are valid in
//   that cycle. The receiver cannot stall; sample the result when done is high.
//   Timing: the command token visits one table cell per clock, entry 0 first.
//   done rises when the token leaves the last cell, and the result is taken
//   at the edge that closes the done cycle. busy stays high through the done
//   cycle, so a new transaction is taken only after the result of the one
//   before it; the walk along the cell chain sets that spacing.
//   Reset: rst (synchronous) empties the table and drops any command in
//   flight; no clearing pass is needed, so a command may follow at once.
// ----------------------------------------------------------------------------
module pending_interest_table
  import pit_pkg::*;
#(
  parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
  parameter int NUM_IFACES  = NUM_IFACES_DEF,
  parameter int NAME_BYTES  = NAME_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [KIND_W-1:0]  kind,
  input  logic [KEY_W-1:0]   name_key,
  input  logic [IFACE_W-1:0] iface,
  input  logic [STATE_W-1:0] new_state,
  output logic               done,
  output logic [STAT_W-1:0]  status,
  output logic               found,
  output logic               all_closed,
  output logic               waiting_valid,
  output logic [IFACE_W-1:0] waiting_iface,
  output logic [STATE_W-1:0] iface_state
);

  localparam logic [KEY_W-1:0] NAME_MASK = {KEY_W{1'b1}} >> (KEY_W - 8 * NAME_BYTES);

  logic     accept;
  logic     busy_next;
  pit_tok_t head;
  pit_tok_t chain [NUM_ENTRIES+1];
  pit_tok_t last;

  assign accept = start && !busy;

  // Build the token at the head of the chain; state code three folds to open.
  always_comb begin
    head           = '0;
    head.active    = accept;
    head.kind      = kind;
    head.key       = name_key & NAME_MASK;
    head.iface     = iface;
    head.new_state = (new_state > IF_OPEN) ? IF_OPEN : new_state;
  end

  assign chain[0] = head;

  // One cell per entry; each hands the token to the next on every clock.
  for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_cell
    pit_cell #(
      .NUM_IFACES(NUM_IFACES),
      .NAME_BYTES(NAME_BYTES)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .tok_in (chain[i]),
      .tok_out(chain[i+1])
    );
  end

  assign last = chain[NUM_ENTRIES];

  // Hold busy from the accepting edge through the done cycle.
  always_comb begin
    busy_next = busy;
    if (accept) begin
      busy_next = 1'b1;
    end else if (last.active) begin
      busy_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= busy_next;
    end
  end

  // Shape the result from the token that left the last cell.
  assign done = last.active;

  always_comb begin
    status        = ST_OK;
    found         = 1'b0;
    all_closed    = 1'b0;
    waiting_valid = 1'b0;
    waiting_iface = '0;
    iface_state   = IF_CLOSED;
    unique case (last.kind)
      KIND_LOOKUP: begin
        status        = last.hit ? ST_OK : ST_NOT_FOUND;
        found         = last.hit;
        all_closed    = last.hit ? last.all_closed : 1'b1;
        waiting_valid = last.waiting_valid;
        waiting_iface = last.waiting_iface;
        iface_state   = last.hit ? last.iface_state : IF_CLOSED;
      end
      KIND_ADD: begin
        status = last.hit ? ST_OK : ST_FULL;
      end
      KIND_REMOVE, KIND_UPDATE: begin
        status = last.hit ? ST_OK : ST_NOT_FOUND;
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

endmodule

// ----- tb/tb_pending_interest_table.sv -----
// ----------------------------------------------------------------------------
// tb_pending_interest_table: self-checking bench for the pending-interest table
// Drives lookup, add, remove, update and clear transactions, first from a
// short directed table and then from phased random traffic. Every transaction
// is predicted on a shadow copy of the table. Each strobed result is checked
// field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_pending_interest_table;
  import pit_pkg::*;

  localparam int N_ENTRIES = NUM_ENTRIES_DEF;
  localparam int N_IFACES  = NUM_IFACES_DEF;
  localparam int N_BYTES   = NAME_BYTES_DEF;

  localparam logic [KEY_W-1:0] KEY_MASK =
    (N_BYTES >= 8) ? {KEY_W{1'b1}} : ((64'd1 << (8 * N_BYTES)) - 64'd1);
  localparam logic [KEY_W-1:0] KEY_ONES = {KEY_W{1'b1}};

  // kinds the block must ignore
  localparam logic [KIND_W-1:0] KIND_RSVD_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_RSVD_HI = 3'd7;

  localparam int RANDOM_ITEMS = 1750;
  localparam int PHASE_ITEMS  = 250;
  // one walk along the cell chain plus the longest sender gap must fit
  // into this several times over before declaring a hang
  localparam int IDLE_LIMIT   = 400;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic               found;
    logic               all_closed;
    logic               waiting_valid;
    logic [IFACE_W-1:0] waiting_iface;
    logic [STATE_W-1:0] iface_state;
  } pit_answer_t;

  // one row of the directed stimulus; typed rows carry their answer
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [KEY_W-1:0]   key;
    logic [IFACE_W-1:0] iface;
    logic [STATE_W-1:0] new_state;
    logic               typed;
    pit_answer_t        answer;
  } pit_row_t;

  logic               clk;
  logic               rst       = 1'b1;
  logic               start     = 1'b0;
  logic [KIND_W-1:0]  kind      = KIND_LOOKUP;
  logic [KEY_W-1:0]   name_key  = '0;
  logic [IFACE_W-1:0] iface     = '0;
  logic [STATE_W-1:0] new_state = IF_CLOSED;
  logic               busy;
  logic               done;
  logic [STAT_W-1:0]  status;
  logic               found;
  logic               all_closed;
  logic               waiting_valid;
  logic [IFACE_W-1:0] waiting_iface;
  logic [STATE_W-1:0] iface_state;

  // shadow copy of the table contents
  bit                 shadow_valid [N_ENTRIES];
  logic [KEY_W-1:0]   shadow_key   [N_ENTRIES];
  logic [STATE_W-1:0] shadow_state [N_ENTRIES][N_IFACES];

  pit_answer_t answers_due[$];
  pit_row_t    directed_rows[$];
  logic [KEY_W-1:0] key_pool [8];
  int errors      = 0;
  int idle_cycles = 0;

  pending_interest_table #(
    .NUM_ENTRIES (N_ENTRIES),
    .NUM_IFACES  (N_IFACES),
    .NAME_BYTES  (N_BYTES)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .kind          (kind),
    .name_key      (name_key),
    .iface         (iface),
    .new_state     (new_state),
    .done          (done),
    .status        (status),
    .found         (found),
    .all_closed    (all_closed),
    .waiting_valid (waiting_valid),
    .waiting_iface (waiting_iface),
    .iface_state   (iface_state)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow table
  // ---------------------------------------------------------------------------

  function automatic void empty_table();
    for (int i = 0; i < N_ENTRIES; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_key[i]   = '0;
      for (int j = 0; j < N_IFACES; j++) shadow_state[i][j] = IF_CLOSED;
    end
  endfunction

  // Return the index of the first live entry holding key, or -1.
  function automatic int first_hit(logic [KEY_W-1:0] key);
    for (int i = 0; i < N_ENTRIES; i++)
      if (shadow_valid[i] && shadow_key[i] == key) return i;
    return -1;
  endfunction

  // Apply one transaction to the shadow table and return the answer the
  // block must give for it.
  function automatic pit_answer_t apply_command(logic [KIND_W-1:0] k,
                                                logic [KEY_W-1:0] key_in,
                                                logic [IFACE_W-1:0] ifc,
                                                logic [STATE_W-1:0] ns_in);
    pit_answer_t        ans;
    logic [KEY_W-1:0]   key;
    logic [STATE_W-1:0] ns;
    int                 hit;
    int                 slot;
    ans  = '0;
    key  = key_in & KEY_MASK;
    // code three folds onto the other open state
    ns   = (ns_in > IF_OPEN) ? IF_OPEN : ns_in;
    hit  = first_hit(key);
    slot = -1;
    case (k)
      KIND_LOOKUP: begin
        ans.all_closed = 1'b1;
        if (hit < 0) begin
          ans.status = ST_NOT_FOUND;
        end else begin
          ans.found = 1'b1;
          for (int j = 0; j < N_IFACES; j++)
            if (shadow_state[hit][j] != IF_CLOSED) ans.all_closed = 1'b0;
          if (ifc < N_IFACES) ans.iface_state = shadow_state[hit][ifc];
          // the waiting search moves on past matches that have none waiting
          for (int i = 0; i < N_ENTRIES; i++) begin
            if (!ans.waiting_valid && shadow_valid[i] && shadow_key[i] == key) begin
              for (int j = 0; j < N_IFACES; j++) begin
                if (!ans.waiting_valid && shadow_state[i][j] == IF_WAITING) begin
                  ans.waiting_valid = 1'b1;
                  ans.waiting_iface = IFACE_W'(j);
                end
              end
            end
          end
        end
      end
      KIND_ADD: begin
        for (int i = N_ENTRIES - 1; i >= 0; i--)
          if (!shadow_valid[i]) slot = i;
        if (slot < 0) begin
          ans.status = ST_FULL;
        end else begin
          shadow_valid[slot] = 1'b1;
          shadow_key[slot]   = key;
          for (int j = 0; j < N_IFACES; j++) shadow_state[slot][j] = ns;
        end
      end
      KIND_REMOVE: begin
        if (hit < 0) begin
          ans.status = ST_NOT_FOUND;
        end else begin
          shadow_valid[hit] = 1'b0;
          shadow_key[hit]   = '0;
          for (int j = 0; j < N_IFACES; j++) shadow_state[hit][j] = IF_CLOSED;
        end
      end
      KIND_UPDATE: begin
        if (hit < 0) ans.status = ST_NOT_FOUND;
        else if (ifc < N_IFACES) shadow_state[hit][ifc] = ns;
      end
      KIND_CLEAR: empty_table();
      default: ;
    endcase
    return ans;
  endfunction

  function automatic pit_answer_t answer(logic [STAT_W-1:0] st, logic f, logic ac,
                                         logic wv, logic [IFACE_W-1:0] wi,
                                         logic [STATE_W-1:0] is);
    pit_answer_t a;
    a.status        = st;
    a.found         = f;
    a.all_closed    = ac;
    a.waiting_valid = wv;
    a.waiting_iface = wi;
    a.iface_state   = is;
    return a;
  endfunction

  // ---------------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------------

  function automatic void add_row(logic [KIND_W-1:0] k, logic [KEY_W-1:0] key,
                                  logic [IFACE_W-1:0] ifc, logic [STATE_W-1:0] ns,
                                  bit typed, pit_answer_t ans);
    pit_row_t r;
    r.kind      = k;
    r.key       = key;
    r.iface     = ifc;
    r.new_state = ns;
    r.typed     = typed;
    r.answer    = ans;
    directed_rows.push_back(r);
  endfunction

  // Present one transaction and hold it until the block takes it. Call right
  // after a rising edge; returns at the accepting edge with start still high.
  task automatic send_cmd(logic [KIND_W-1:0] k, logic [KEY_W-1:0] key,
                          logic [IFACE_W-1:0] ifc, logic [STATE_W-1:0] ns,
                          bit typed, pit_answer_t typed_ans);
    pit_answer_t ans;
    start     <= 1'b1;
    kind      <= k;
    name_key  <= key;
    iface     <= ifc;
    new_state <= ns;
    do @(posedge clk); while (busy);
    // advance the shadow table even when the answer is typed in
    ans = apply_command(k, key, ifc, ns);
    answers_due.push_back(typed ? typed_ans : ans);
  endtask

  initial begin
    pit_answer_t ok_ans;
    pit_answer_t miss_ans;
    pit_answer_t zero_ans;
    logic [KIND_W-1:0]  k;
    logic [KEY_W-1:0]   key;
    logic [STATE_W-1:0] ns;
    int items_done;
    int burst_left;
    int phase;
    int pick;
    int cut_lookup, cut_add, cut_remove, cut_update, cut_clear;

    empty_table();
    ok_ans   = answer(ST_OK, 1'b0, 1'b0, 1'b0, '0, IF_CLOSED);
    miss_ans = answer(ST_NOT_FOUND, 1'b0, 1'b0, 1'b0, '0, IF_CLOSED);
    zero_ans = '0;

    // Directed rows. Start on an empty table: a zero key must not match the
    // cleared entries, and every miss reports not found.
    add_row(KIND_LOOKUP, '0, 3'd0, IF_CLOSED, 1'b1,
            answer(ST_NOT_FOUND, 1'b0, 1'b1, 1'b0, '0, IF_CLOSED));
    add_row(KIND_REMOVE, '0, 3'd0, IF_CLOSED, 1'b1, miss_ans);
    add_row(KIND_UPDATE, KEY_ONES, 3'd7, IF_WAITING, 1'b1, miss_ans);
    // Fill every slot. Slot 1 takes state code three, slot 3 repeats the
    // all-ones key with every interface waiting.
    for (int i = 0; i < N_ENTRIES; i++) begin
      case (i)
        0:       begin key = '0;       ns = IF_CLOSED;  end
        1:       begin key = KEY_ONES; ns = 2'd3;       end
        3:       begin key = KEY_ONES; ns = IF_WAITING; end
        default: begin key = 64'h0101_0101_0101_0101 * i; ns = STATE_W'(i % 3); end
      endcase
      add_row(KIND_ADD, key, 3'(i), ns, 1'b1, ok_ans);
    end
    add_row(KIND_ADD, 64'h8000_0000_0000_1234, 3'd0, IF_OPEN, 1'b1,
            answer(ST_FULL, 1'b0, 1'b0, 1'b0, '0, IF_CLOSED));
    // first match is open everywhere, the waiting one comes from the duplicate
    add_row(KIND_LOOKUP, KEY_ONES, 3'd4, IF_CLOSED, 1'b0, zero_ans);
    add_row(KIND_UPDATE, KEY_ONES, 3'd6, IF_WAITING, 1'b1, ok_ans);
    add_row(KIND_LOOKUP, KEY_ONES, 3'd6, IF_CLOSED, 1'b0, zero_ans);
    add_row(KIND_RSVD_LO, KEY_ONES, 3'd7, 2'd3, 1'b1, zero_ans);
    add_row(KIND_RSVD_HI, '0, 3'd7, 2'd3, 1'b1, zero_ans);
    add_row(KIND_REMOVE, KEY_ONES, 3'd0, IF_CLOSED, 1'b1, ok_ans);
    add_row(KIND_LOOKUP, KEY_ONES, 3'd2, IF_CLOSED, 1'b0, zero_ans);
    add_row(KIND_LOOKUP, '0, 3'd7, IF_CLOSED, 1'b0, zero_ans);
    add_row(KIND_ADD, 64'h5555_5555_5555_5555, 3'd0, IF_OPEN, 1'b1, ok_ans);
    add_row(KIND_CLEAR, KEY_ONES, 3'd7, 2'd3, 1'b1, ok_ans);
    add_row(KIND_LOOKUP, '0, 3'd0, IF_CLOSED, 1'b1,
            answer(ST_NOT_FOUND, 1'b0, 1'b1, 1'b0, '0, IF_CLOSED));

    // Small key pool so that random transactions hit live entries; two pairs of
    // members differ in a single bit, the top bit in one pair and bit 0 in the other.
    key_pool[0] = '0;
    key_pool[1] = KEY_ONES;
    key_pool[2] = {$urandom, $urandom};
    key_pool[3] = key_pool[2] ^ (64'd1 << 63);
    key_pool[4] = {$urandom, $urandom};
    key_pool[5] = key_pool[4] ^ 64'd1;
    key_pool[6] = {32'd0, $urandom};
    key_pool[7] = {$urandom, 32'd0};

    // hold reset, then issue the first transaction at once
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[n])
      send_cmd(directed_rows[n].kind, directed_rows[n].key, directed_rows[n].iface,
               directed_rows[n].new_state, directed_rows[n].typed, directed_rows[n].answer);

    // Random traffic in phases: filling (runs into full), mixed, draining.
    items_done = 0;
    burst_left = $urandom_range(1, 20);
    while (items_done < RANDOM_ITEMS) begin
      phase = (items_done / PHASE_ITEMS) % 3;
      case (phase)
        0:       begin cut_lookup = 25; cut_add = 70; cut_remove = 80; cut_update = 95; end
        1:       begin cut_lookup = 35; cut_add = 57; cut_remove = 75; cut_update = 95; end
        default: begin cut_lookup = 30; cut_add = 40; cut_remove = 75; cut_update = 95; end
      endcase
      cut_clear = cut_update + 1;
      pick = $urandom_range(0, 99);
      if (pick < cut_lookup)      k = KIND_LOOKUP;
      else if (pick < cut_add)    k = KIND_ADD;
      else if (pick < cut_remove) k = KIND_REMOVE;
      else if (pick < cut_update) k = KIND_UPDATE;
      else if (pick < cut_clear)  k = KIND_CLEAR;
      else                        k = KIND_W'($urandom_range(KIND_RSVD_LO, KIND_RSVD_HI));
      if ($urandom_range(0, 6) == 0) key = {$urandom, $urandom};
      else                           key = key_pool[$urandom_range(0, 7)];
      send_cmd(k, key, IFACE_W'($urandom_range(0, 7)), STATE_W'($urandom_range(0, 3)),
               1'b0, zero_ans);
      // ignored kinds do not count toward the traffic total
      if (k <= KIND_CLEAR) items_done++;
      burst_left--;
      if (burst_left == 0) begin
        // drop start for a gap of random length; skip it now and then so
        // back-to-back stretches occur too
        if ($urandom_range(0, 3) != 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 24)) @(posedge clk);
        end
        burst_left = $urandom_range(1, 20);
      end
    end
    start <= 1'b0;

    // drain outstanding results, then watch for stray strobes
    while (answers_due.size() != 0) @(posedge clk);
    repeat (2 * N_ENTRIES + 4) @(posedge clk);
    if (errors == 0 && answers_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: the block strobes done for one cycle and cannot be held off,
  // so check every strobe at the edge that closes it.
  // ---------------------------------------------------------------------------

  task automatic check_field(string fname, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
    end
  endtask

  always @(posedge clk) begin
    pit_answer_t want;
    if (!rst && done) begin
      if (answers_due.size() == 0) begin
        errors++;
        $display("%0t: result with no transaction outstanding, expected none, actual status %0d",
                 $time, status);
      end else begin
        want = answers_due.pop_front();
        check_field("status",        want.status,        status);
        check_field("found",         want.found,         found);
        check_field("all_closed",    want.all_closed,    all_closed);
        check_field("waiting_valid", want.waiting_valid, waiting_valid);
        check_field("waiting_iface", want.waiting_iface, waiting_iface);
        check_field("iface_state",   want.iface_state,   iface_state);
      end
    end
  end

  // Watchdog: restart on every accepted command or result, end the run when
  // nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
